>>> hw/rtl/bt_pkg.sv
// Shared types and constants for the base timer with two interrupt sources.
// No dependencies; every other file of the block uses this package.
package bt_pkg;

    localparam int STEP_W  = 17;
    localparam int PHASE_W = 16;
    localparam int COUNT_W = 14;
    localparam int CTL_W   = 8;

    // Opcode of an input item.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Phase step that makes exactly one count (1.0 in Q1.16).
    localparam logic [STEP_W-1:0] PHASE_ONE = 17'h10000;

    // Control register bit positions.
    localparam int CTL_S0_EN   = 0;
    localparam int CTL_S0_FLAG = 1;
    localparam int CTL_S1_EN   = 2;
    localparam int CTL_S1_FLAG = 3;
    localparam int CTL_S1_SEL0 = 4;
    localparam int CTL_S1_SEL1 = 5;
    localparam int CTL_RUN     = 6;
    localparam int CTL_S0_PER  = 7;

    // Source 1 period select codes.
    localparam logic [1:0] S1_PER_32   = 2'd0;
    localparam logic [1:0] S1_PER_128  = 2'd1;
    localparam logic [1:0] S1_PER_512  = 2'd2;
    localparam logic [1:0] S1_PER_2048 = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [STEP_W-1:0]  phase_step;
        logic [CTL_W-1:0]   write_value;
    } in_item_t;

    typedef struct packed {
        logic [CTL_W-1:0]   control_value;
        logic [COUNT_W-1:0] count_value;
        logic               irq_request;
    } out_item_t;

    // Mask of the count bits that must be zero when source 1 completes a period.
    function automatic logic [COUNT_W-1:0] s1_mask(input logic [1:0] sel);
        logic [COUNT_W-1:0] m;
        case (sel)
            S1_PER_32:   m = 14'h001F;
            S1_PER_128:  m = 14'h007F;
            S1_PER_512:  m = 14'h01FF;
            S1_PER_2048: m = 14'h07FF;
            default:     m = 14'h07FF;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/bt_in_if.sv
// Input channel of the base timer: valid/ready handshake with the item fields.
// Depends on bt_pkg for field widths.
interface bt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [bt_pkg::STEP_W-1:0]   phase_step;
    logic [bt_pkg::CTL_W-1:0]    write_value;

    modport source (output valid, output opcode, output phase_step, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input phase_step, input write_value,
                    output ready);
endinterface

>>> hw/rtl/bt_out_if.sv
// Result channel of the base timer: valid/ready handshake with the result fields.
// Depends on bt_pkg for field widths.
interface bt_out_if;
    logic                        valid;
    logic                        ready;
    logic [bt_pkg::CTL_W-1:0]    control_value;
    logic [bt_pkg::COUNT_W-1:0]  count_value;
    logic                        irq_request;

    modport source (output valid, output control_value, output count_value,
                    output irq_request, input ready);
    modport sink   (input valid, input control_value, input count_value,
                    input irq_request, output ready);
endinterface

>>> hw/rtl/base_timer_with_dual_interrupts_top.sv
// Base timer with two interrupt sources, counting crystal periods from Q1.16
// phase steps. An item passes through an input register, the combinational
// update logic and a result register; its result is registered when the held
// item moves on, once the result register is empty or being emptied. One item
// is accepted every cycle as long as results are taken, because the timer
// state update is combinational. While a finished result waits in the result
// register, the input side takes at most one more item and then holds ready low.
// Depends on bt_pkg, bt_in_if, bt_out_if, bt_in_stage and bt_core.
module base_timer_with_dual_interrupts_top (
    input  logic  clk,
    input  logic  rst_n,
    bt_in_if.sink     in_ch,
    bt_out_if.source  out_ch
);
    import bt_pkg::*;

    in_item_t  item;
    logic      item_valid;
    out_item_t result;
    logic      advance;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;

    // The held item moves on when the result register is empty or being emptied.
    assign advance = item_valid && (!out_valid_reg || out_ch.ready);

    bt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    bt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.control_value = out_reg.control_value;
    assign out_ch.count_value   = out_reg.count_value;
    assign out_ch.irq_request   = out_reg.irq_request;

endmodule

>>> hw/rtl/bt_in_stage.sv
// Input register of the base timer: captures one item from the input channel.
// Depends on bt_pkg and bt_in_if.
module bt_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    bt_in_if.sink            in_ch,
    input  logic             advance,
    output bt_pkg::in_item_t item,
    output logic             item_valid
);
    import bt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // The held item leaves when the core consumes it, freeing the slot the same cycle.
    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.opcode      <= in_ch.opcode;
            item_reg.phase_step  <= in_ch.phase_step;
            item_reg.write_value <= in_ch.write_value;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

>>> hw/rtl/bt_core.sv
// Timer state (control, count, phase) and the combinational update for one item.
// Depends on bt_pkg.
module bt_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  bt_pkg::in_item_t  item,
    output bt_pkg::out_item_t result
);
    import bt_pkg::*;

    logic [CTL_W-1:0]   control_reg;
    logic [CTL_W-1:0]   control_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    logic [STEP_W-1:0]  step_sat;
    logic [STEP_W-1:0]  sum;
    logic               carry;
    logic [COUNT_W-1:0] count_inc;
    logic               fire1;
    logic               fire0;
    logic               irq;

    always_comb
    begin
        step_sat  = (item.phase_step > PHASE_ONE) ? PHASE_ONE : item.phase_step;
        sum       = {1'b0, phase_reg} + step_sat;
        carry     = sum[STEP_W-1];
        count_inc = count_reg + 1'b1;
        fire1     = ((count_inc & s1_mask(control_reg[CTL_S1_SEL1:CTL_S1_SEL0])) == '0);
        // Source 0 fires on every 64th count when CTL_S0_PER is set, else when the count wraps to zero.
        fire0     = control_reg[CTL_S0_PER] ? (count_inc[5:0] == '0) : (count_inc == '0);

        control_next = control_reg;
        count_next   = count_reg;
        phase_next   = phase_reg;
        irq          = 1'b0;

        if (item.opcode == OP_WRITE)
        begin
            control_next = item.write_value;
        end
        else if (!control_reg[CTL_RUN])
        begin
            count_next = '0;
            phase_next = '0;
        end
        else
        begin
            phase_next = sum[PHASE_W-1:0];
            if (carry)
            begin
                count_next = count_inc;
                if (fire1)
                begin
                    control_next[CTL_S1_FLAG] = 1'b1;
                end
                if (fire0)
                begin
                    control_next[CTL_S0_FLAG] = 1'b1;
                end
                irq = (fire1 && control_reg[CTL_S1_EN]) || (fire0 && control_reg[CTL_S0_EN]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= '0;
            count_reg   <= '0;
            phase_reg   <= '0;
        end
        else if (advance)
        begin
            control_reg <= control_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
        end
    end

    assign result.control_value = control_next;
    assign result.count_value   = count_next;
    assign result.irq_request   = irq;

endmodule

>>> tb/tb_base_timer_with_dual_interrupts_top.sv
// Self-checking testbench for the base timer with two interrupt sources: tick and
// control-write items with random stalls, each result checked against a local timer model.
// Depends on bt_pkg, bt_in_if, bt_out_if and base_timer_with_dual_interrupts_top.
module tb_base_timer_with_dual_interrupts_top;

    import bt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_PCT = 27;
    localparam logic [STEP_W-1:0] STEP_MAX = 17'h1FFFF;

    logic clk;
    logic rst_n;

    bt_in_if  in_ch();
    bt_out_if out_ch();

    base_timer_with_dual_interrupts_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Timer state as the testbench expects it.
    logic [CTL_W-1:0]   ctl_model;
    logic [COUNT_W-1:0] count_model;
    logic [PHASE_W-1:0] phase_model;

    in_item_t  stim_q[$];
    out_item_t timer_expect_q[$];
    in_item_t  next_item;
    out_item_t predicted;
    out_item_t wanted;

    int cycle_cnt = 0;
    int errors = 0;
    int items_accepted = 0;
    int writes_queued = 0;
    int results_checked = 0;
    int irq_seen = 0;
    int count_wraps = 0;
    int both_fired = 0;
    logic calm;

    // A stretch of the run in which neither side stalls.
    assign calm = (cycle_cnt >= 1500) && (cycle_cnt < 4500);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic predict_timer(input in_item_t it, output out_item_t res);
        logic [STEP_W-1:0]  step;
        logic [STEP_W:0]    sum;
        logic [CTL_W-1:0]   ctl_then;
        logic [COUNT_W-1:0] s1_low;
        logic [COUNT_W-1:0] s0_low;
        logic               s1_hit;
        logic               s0_hit;
        logic               irq;
        irq = 1'b0;
        if (it.opcode == OP_WRITE)
        begin
            ctl_model = it.write_value;
        end
        else if (!ctl_model[CTL_RUN])
        begin
            count_model = '0;
            phase_model = '0;
        end
        else
        begin
            step = (it.phase_step > PHASE_ONE) ? PHASE_ONE : it.phase_step;
            sum = phase_model + step;
            if (sum >= PHASE_ONE)
            begin
                sum = sum - PHASE_ONE;
                // Periods and enables come from the register as it stood before this count.
                ctl_then = ctl_model;
                count_model = count_model + 1'b1;
                if (count_model == '0)
                    count_wraps++;
                case (ctl_then[CTL_S1_SEL1:CTL_S1_SEL0])
                    S1_PER_32:   s1_low = 14'd31;
                    S1_PER_128:  s1_low = 14'd127;
                    S1_PER_512:  s1_low = 14'd511;
                    default:     s1_low = 14'd2047;
                endcase
                s0_low = ctl_then[CTL_S0_PER] ? 14'd63 : 14'h3FFF;
                s1_hit = ((count_model & s1_low) == '0);
                s0_hit = ((count_model & s0_low) == '0);
                if (s1_hit)
                begin
                    ctl_model[CTL_S1_FLAG] = 1'b1;
                    if (ctl_then[CTL_S1_EN])
                        irq = 1'b1;
                end
                if (s0_hit)
                begin
                    ctl_model[CTL_S0_FLAG] = 1'b1;
                    if (ctl_then[CTL_S0_EN])
                        irq = 1'b1;
                end
                if (s1_hit && s0_hit)
                    both_fired++;
            end
            phase_model = sum[PHASE_W-1:0];
        end
        res.control_value = ctl_model;
        res.count_value = count_model;
        res.irq_request = irq;
    endtask

    task automatic check_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what,
                     want_v, got_v);
        end
    endtask

    task automatic queue_tick(input logic [STEP_W-1:0] step);
        in_item_t it;
        it.opcode = OP_TICK;
        it.phase_step = step;
        it.write_value = CTL_W'($urandom_range(255));
        stim_q.push_back(it);
    endtask

    task automatic queue_write(input logic [CTL_W-1:0] value);
        in_item_t it;
        it.opcode = OP_WRITE;
        it.phase_step = STEP_W'($urandom_range(STEP_MAX));
        it.write_value = value;
        stim_q.push_back(it);
        writes_queued++;
    endtask

    // Mostly whole counts, some saturating steps, some fractional ones.
    function automatic logic [STEP_W-1:0] pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return PHASE_ONE;
        else if (r < 80)
            return STEP_W'($urandom_range(STEP_MAX, PHASE_ONE + 1));
        else
            return STEP_W'($urandom_range(PHASE_ONE - 1));
    endfunction

    task automatic wait_for_drain();
        while (stim_q.size() != 0 || in_ch.valid || timer_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Sender: predicts each accepted item and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.opcode <= OP_TICK;
            in_ch.phase_step <= '0;
            in_ch.write_value <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_timer(in_item_t'{in_ch.opcode, in_ch.phase_step, in_ch.write_value},
                              predicted);
                timer_expect_q.push_back(predicted);
                items_accepted++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (stim_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_item = stim_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.opcode <= next_item.opcode;
                    in_ch.phase_step <= next_item.phase_step;
                    in_ch.write_value <= next_item.write_value;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (timer_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual ctl 0x%0h count %0d irq %0b",
                         $time, out_ch.control_value, out_ch.count_value, out_ch.irq_request);
            end
            else
            begin
                wanted = timer_expect_q.pop_front();
                check_field("control_value", 32'(wanted.control_value),
                            32'(out_ch.control_value));
                check_field("count_value", 32'(wanted.count_value), 32'(out_ch.count_value));
                check_field("irq_request", 32'(wanted.irq_request), 32'(out_ch.irq_request));
                results_checked++;
                if (out_ch.irq_request)
                    irq_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_base_timer_with_dual_interrupts_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [CTL_W-1:0] ctl;
        int n_rand;
        int len;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_TICK;
        in_ch.phase_step = '0;
        in_ch.write_value = '0;
        out_ch.ready = 1'b0;
        ctl_model = '0;
        count_model = '0;
        phase_model = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stopped timer, fractional carries, step saturation, writes mid-count.
        queue_tick(PHASE_ONE);
        queue_write(8'h45);
        queue_tick('0);
        queue_tick(PHASE_ONE - 1);
        queue_tick(17'd1);
        queue_tick(STEP_MAX);
        queue_tick(PHASE_ONE + 1);
        queue_tick(17'h08000);
        queue_tick(17'h08000);
        queue_write(8'hFF);
        queue_tick(PHASE_ONE);
        queue_write(8'h00);
        queue_tick(17'd100);
        queue_write(8'hF5);
        repeat (8) queue_tick(PHASE_ONE);
        queue_write(8'hC5);
        queue_tick(STEP_MAX);
        wait_for_drain();

        // Random: mostly a running configuration followed by a burst of ticks.
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 75)
            begin
                ctl = CTL_W'($urandom_range(255));
                ctl[CTL_RUN] = 1'b1;
                if ($urandom_range(1))
                begin
                    ctl[CTL_S0_FLAG] = 1'b0;
                    ctl[CTL_S1_FLAG] = 1'b0;
                end
                queue_write(ctl);
                n_rand++;
                len = $urandom_range(150, 20);
                repeat (len)
                begin
                    // Now and then software clears the flags while the timer runs.
                    if ($urandom_range(99) < 3)
                    begin
                        ctl[CTL_S0_FLAG] = 1'b0;
                        ctl[CTL_S1_FLAG] = 1'b0;
                        queue_write(ctl);
                    end
                    else
                    begin
                        queue_tick(pick_step());
                    end
                    n_rand++;
                end
            end
            else
            begin
                repeat ($urandom_range(10, 1))
                begin
                    if ($urandom_range(1))
                        queue_write(CTL_W'($urandom_range(255)));
                    else
                        queue_tick(STEP_W'($urandom_range(STEP_MAX)));
                    n_rand++;
                end
            end
        end
        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("Run covered %0d items (%0d control writes) and %0d checked results.",
                 items_accepted, writes_queued, results_checked);
        $display("Saw %0d interrupt requests, %0d counts firing both sources, %0d count wraps.",
                 irq_seen, both_fired, count_wraps);
        if (errors == 0 && timer_expect_q.size() == 0)
            $display("tb_base_timer_with_dual_interrupts_top: done, clean");
        else
            $display("tb_base_timer_with_dual_interrupts_top: done, errors");
        $finish;
    end

endmodule
